// ===== rtl/core/mcs96pd_pkg.sv =====
package mcs96pd_pkg;

  // default width of the program counter
  localparam int unsigned ADDRESS_WIDTH = 16;

  // most bytes one instruction can occupy
  localparam int unsigned MAX_BYTES = 6;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_START = 1'b0,
    CFG_END   = 1'b1
  } cfg_reg_e;

  // instruction groups
  typedef enum logic [4:0] {
    GRP_UNDEF    = 5'd0,
    GRP_ARITH_A  = 5'd1,
    GRP_ARITH_B  = 5'd2,
    GRP_SINGLE   = 5'd3,
    GRP_ONEBYTE  = 5'd4,
    GRP_CONDJUMP = 5'd5,
    GRP_SHIFT    = 5'd6,
    GRP_JBC      = 5'd7,
    GRP_JBS      = 5'd8,
    GRP_DJNZ     = 5'd9,
    GRP_PUSHPOP  = 5'd10,
    GRP_STORE    = 5'd11,
    GRP_LJMP     = 5'd12,
    GRP_LCALL    = 5'd13,
    GRP_SJMP     = 5'd14,
    GRP_SCALL    = 5'd15,
    GRP_BR       = 5'd16,
    GRP_PREFIX   = 5'd17
  } group_e;

  // addressing modes
  typedef enum logic [1:0] {
    AM_DIRECT   = 2'd0,
    AM_IMMEDIATE = 2'd1,
    AM_INDIRECT = 2'd2,
    AM_INDEXED  = 2'd3
  } addr_mode_e;

  // bytes of the instruction being gathered
  typedef logic [MAX_BYTES-1:0][7:0] code_bytes_t;

  // one decoded instruction record
  typedef struct packed {
    logic [15:0] instr_addr;
    logic [2:0]  length;
    group_e      group;
    logic [3:0]  sub_op;
    logic [1:0]  flags;
    addr_mode_e  addr_mode;
    logic [1:0]  reg_count;
    logic [7:0]  base_reg;
    logic [15:0] word_value;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [15:0] target;
  } record_t;

endpackage

// ===== rtl/core/mcs96pd_decode.sv =====
module mcs96pd_decode #(
  parameter int unsigned AddrWidth = mcs96pd_pkg::ADDRESS_WIDTH
) (
  input  mcs96pd_pkg::code_bytes_t bytes_i,
  input  logic [2:0]               have_i,
  input  logic [AddrWidth-1:0]     pc_i,
  output logic                     complete_o,
  output logic [AddrWidth-1:0]     next_pc_o,
  output mcs96pd_pkg::record_t     rec_o
);

  // pick one gathered byte by position
  function automatic logic [7:0] byte_at(mcs96pd_pkg::code_bytes_t b, logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = b[0];
      3'd1: r = b[1];
      3'd2: r = b[2];
      3'd3: r = b[3];
      3'd4: r = b[4];
      3'd5: r = b[5];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic [7:0]             op, b1, b2, b3;
  mcs96pd_pkg::group_e    grp;
  logic [3:0]             sub;
  logic                   bytef;
  mcs96pd_pkg::addr_mode_e am;
  logic                   has_op;
  logic [2:0]             op_len;
  logic [2:0]             len;
  logic [2:0]             p;
  logic [AddrWidth-1:0]   step;
  logic [AddrWidth-1:0]   offset;

  assign op = bytes_i[0];
  assign b1 = bytes_i[1];
  assign b2 = bytes_i[2];
  assign b3 = bytes_i[3];

  // opcode classification
  always_comb begin
    sub    = 4'd0;
    bytef  = 1'b0;
    am     = mcs96pd_pkg::AM_DIRECT;
    has_op = 1'b0;
    grp    = mcs96pd_pkg::GRP_UNDEF;
    priority if (op == 8'hfe) begin
      grp = mcs96pd_pkg::GRP_PREFIX;
    end else if (op[7:6] == 2'b01) begin
      grp    = mcs96pd_pkg::GRP_ARITH_A;
      has_op = 1'b1;
      am     = mcs96pd_pkg::addr_mode_e'(op[1:0]);
      bytef  = op[4];
      sub    = {2'b00, op[3:2]};
    end else if (op[7:6] == 2'b10) begin
      grp    = mcs96pd_pkg::GRP_ARITH_B;
      has_op = 1'b1;
      am     = mcs96pd_pkg::addr_mode_e'(op[1:0]);
      bytef  = op[4];
      sub    = {1'b0, op[5], op[3:2]};
    end else if ((op & 8'he8) == 8'h00) begin
      grp   = mcs96pd_pkg::GRP_SINGLE;
      sub   = {1'b0, op[2:0]};
      bytef = op[4];
    end else if (op[7:4] == 4'hf) begin
      grp = mcs96pd_pkg::GRP_ONEBYTE;
      sub = op[3:0];
    end else if (op[7:4] == 4'hd) begin
      grp = mcs96pd_pkg::GRP_CONDJUMP;
      sub = op[3:0];
    end else if ((op & 8'he8) == 8'h08) begin
      grp   = mcs96pd_pkg::GRP_SHIFT;
      sub   = {op[4], op[2:0]};
      bytef = op[4];
    end else if (op[7:3] == 5'b00110) begin
      grp = mcs96pd_pkg::GRP_JBC;
      sub = {1'b0, op[2:0]};
    end else if (op[7:3] == 5'b00111) begin
      grp = mcs96pd_pkg::GRP_JBS;
      sub = {1'b0, op[2:0]};
    end else if (op == 8'he0) begin
      grp = mcs96pd_pkg::GRP_DJNZ;
    end else if (op[7:3] == 5'b11001) begin
      grp    = mcs96pd_pkg::GRP_PUSHPOP;
      has_op = 1'b1;
      am     = mcs96pd_pkg::addr_mode_e'(op[1:0]);
      bytef  = op[4];
      sub    = {3'b000, op[2]};
    end else if (op[7:3] == 5'b11000) begin
      grp    = mcs96pd_pkg::GRP_STORE;
      has_op = 1'b1;
      am     = mcs96pd_pkg::addr_mode_e'(op[1:0]);
      bytef  = op[2];
    end else if (op == 8'he7) begin
      grp = mcs96pd_pkg::GRP_LJMP;
    end else if (op == 8'hef) begin
      grp = mcs96pd_pkg::GRP_LCALL;
    end else if (op[7:3] == 5'b00100) begin
      grp = mcs96pd_pkg::GRP_SJMP;
    end else if (op[7:3] == 5'b00101) begin
      grp = mcs96pd_pkg::GRP_SCALL;
    end else if (op == 8'he3) begin
      grp = mcs96pd_pkg::GRP_BR;
    end else begin
      grp = mcs96pd_pkg::GRP_UNDEF;
    end
  end

  // general operand length and instruction length
  always_comb begin
    unique case (am)
      mcs96pd_pkg::AM_IMMEDIATE: op_len = bytef ? 3'd1 : 3'd2;
      mcs96pd_pkg::AM_INDEXED:   op_len = (have_i >= 3'd2 && b1[0]) ? 3'd3 : 3'd2;
      default:                   op_len = 3'd1;
    endcase
    unique case (grp)
      mcs96pd_pkg::GRP_ARITH_A: len = 3'd1 + op_len + (op[5] ? 3'd1 : 3'd2);
      mcs96pd_pkg::GRP_ARITH_B,
      mcs96pd_pkg::GRP_STORE:   len = 3'd2 + op_len;
      mcs96pd_pkg::GRP_PUSHPOP: len = 3'd1 + op_len;
      mcs96pd_pkg::GRP_SINGLE,
      mcs96pd_pkg::GRP_CONDJUMP,
      mcs96pd_pkg::GRP_SJMP,
      mcs96pd_pkg::GRP_SCALL,
      mcs96pd_pkg::GRP_BR:      len = 3'd2;
      mcs96pd_pkg::GRP_SHIFT,
      mcs96pd_pkg::GRP_JBC,
      mcs96pd_pkg::GRP_JBS,
      mcs96pd_pkg::GRP_DJNZ,
      mcs96pd_pkg::GRP_LJMP,
      mcs96pd_pkg::GRP_LCALL:   len = 3'd3;
      default:                  len = 3'd1;
    endcase
  end

  assign p          = 3'd1 + op_len;
  assign complete_o = (have_i >= len);
  assign next_pc_o  = pc_i + AddrWidth'(len);

  // operand fields and branch displacement
  always_comb begin
    rec_o            = '0;
    rec_o.instr_addr = pc_i[15:0];
    rec_o.length     = len;
    rec_o.group      = grp;
    rec_o.sub_op     = sub;
    rec_o.flags      = {1'b0, bytef};
    rec_o.addr_mode  = am;
    step             = '0;
    offset           = '0;

    // general operand
    if (has_op) begin
      unique case (am)
        mcs96pd_pkg::AM_DIRECT: begin
          rec_o.base_reg = b1;
        end
        mcs96pd_pkg::AM_IMMEDIATE: begin
          rec_o.word_value = bytef ? {8'h00, b1} : {b2, b1};
        end
        mcs96pd_pkg::AM_INDIRECT: begin
          rec_o.base_reg = {b1[7:1], 1'b0};
          rec_o.flags[1] = b1[0];
        end
        default: begin
          rec_o.base_reg   = {b1[7:1], 1'b0};
          rec_o.flags[1]   = b1[0];
          rec_o.word_value = b1[0] ? {b3, b2} : {8'h00, b2};
        end
      endcase
      if (grp != mcs96pd_pkg::GRP_PUSHPOP) begin
        rec_o.reg_b     = byte_at(bytes_i, p);
        rec_o.reg_count = 2'd1;
        if (grp == mcs96pd_pkg::GRP_ARITH_A && !op[5]) begin
          rec_o.reg_c     = byte_at(bytes_i, p + 3'd1);
          rec_o.reg_count = 2'd2;
        end
      end
    end

    // group specific operands
    unique case (grp)
      mcs96pd_pkg::GRP_SINGLE,
      mcs96pd_pkg::GRP_BR: begin
        rec_o.reg_b     = b1;
        rec_o.reg_count = 2'd1;
      end
      mcs96pd_pkg::GRP_CONDJUMP: begin
        step   = AddrWidth'(2);
        offset = AddrWidth'($signed(b1));
      end
      mcs96pd_pkg::GRP_SHIFT: begin
        rec_o.word_value = {8'h00, b1};
        rec_o.reg_b      = b2;
        rec_o.reg_count  = 2'd1;
      end
      mcs96pd_pkg::GRP_JBC,
      mcs96pd_pkg::GRP_JBS,
      mcs96pd_pkg::GRP_DJNZ: begin
        rec_o.reg_b     = b1;
        rec_o.reg_count = 2'd1;
        step            = AddrWidth'(3);
        offset          = AddrWidth'($signed(b2));
      end
      mcs96pd_pkg::GRP_LJMP,
      mcs96pd_pkg::GRP_LCALL: begin
        step   = AddrWidth'(3);
        offset = AddrWidth'($signed({b2, b1}));
      end
      mcs96pd_pkg::GRP_SJMP,
      mcs96pd_pkg::GRP_SCALL: begin
        step   = AddrWidth'(2);
        offset = AddrWidth'($signed({op[2:0], b1}));
      end
      default: begin
      end
    endcase

    // relative target from the address after the instruction
    if (step != '0) begin
      rec_o.target = 16'(pc_i + step + offset);
    end
  end

endmodule

// ===== rtl/core/mcs96_instruction_predecoder_unit.sv =====
// a record goes to the output register, or to the skid register while that one is held
// throughput: one code byte per cycle; bytes keep flowing while one record waits in the
// output register, the input stalls only while a second record waits in the skid register
// reset: program counter 0, end address 0xffff, byte count 0, not stopped, output empty;
// gathered bytes are not reset
module mcs96_instruction_predecoder_unit #(
  parameter int unsigned ADDRESS_WIDTH = mcs96pd_pkg::ADDRESS_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // code byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  // decoded records
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] instr_addr_o,
  output logic [2:0]  length_o,
  output logic [4:0]  group_o,
  output logic [3:0]  sub_op_o,
  output logic [1:0]  flags_o,
  output logic [1:0]  addr_mode_o,
  output logic [1:0]  reg_count_o,
  output logic [7:0]  base_reg_o,
  output logic [15:0] word_value_o,
  output logic [7:0]  reg_b_o,
  output logic [7:0]  reg_c_o,
  output logic [15:0] target_o
);

  logic [ADDRESS_WIDTH-1:0] pc_q;
  logic [15:0]              end_q;
  logic [2:0]               idx_q;
  logic                     stopped_q;
  mcs96pd_pkg::code_bytes_t bytes_q;

  logic                     in_acc, cfg_acc, work;
  logic [2:0]               idx_eff;
  mcs96pd_pkg::code_bytes_t cur_bytes;
  logic                     complete;
  logic [ADDRESS_WIDTH-1:0] next_pc;
  mcs96pd_pkg::record_t     rec;
  logic                     rec_valid;

  logic                     out_valid_q, skid_valid_q;
  mcs96pd_pkg::record_t     out_q, skid_q;
  logic                     out_pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign work        = in_acc & ~stopped_q;
  assign idx_eff     = (idx_q > 3'd5) ? 3'd0 : idx_q;

  // current byte merged into the gathered bytes
  always_comb begin
    cur_bytes = bytes_q;
    for (int i = 0; i < int'(mcs96pd_pkg::MAX_BYTES); i++) begin
      if (idx_eff == 3'(i)) begin
        cur_bytes[i] = code_byte_i;
      end
    end
  end

  mcs96pd_decode #(
    .AddrWidth(ADDRESS_WIDTH)
  ) u_decode (
    .bytes_i   (cur_bytes),
    .have_i    (idx_eff + 3'd1),
    .pc_i      (pc_q),
    .complete_o(complete),
    .next_pc_o (next_pc),
    .rec_o     (rec)
  );

  assign rec_valid = work & complete;

  // gathered byte storage
  always_ff @(posedge clk_i) begin
    if (work) begin
      bytes_q[idx_eff] <= code_byte_i;
    end
  end

  // program counter, byte count and stop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      end_q     <= 16'hffff;
      idx_q     <= 3'd0;
      stopped_q <= 1'b0;
    end else begin
      if (work) begin
        if (complete) begin
          pc_q      <= next_pc;
          idx_q     <= 3'd0;
          stopped_q <= (next_pc >= ADDRESS_WIDTH'(end_q));
        end else begin
          idx_q <= idx_eff + 3'd1;
        end
      end
      if (cfg_acc) begin
        unique case (cfg_index_i)
          mcs96pd_pkg::CFG_START: begin
            pc_q      <= ADDRESS_WIDTH'(cfg_data_i);
            idx_q     <= 3'd0;
            stopped_q <= 1'b0;
          end
          default: begin
            end_q <= cfg_data_i;
          end
        endcase
      end
    end
  end

  // output register with skid stage
  assign out_pop = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (rec_valid) begin
        if (out_valid_q && !out_pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // record payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (rec_valid) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= rec;
      end else begin
        out_q <= rec;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign instr_addr_o = out_q.instr_addr;
  assign length_o     = out_q.length;
  assign group_o      = out_q.group;
  assign sub_op_o     = out_q.sub_op;
  assign flags_o      = out_q.flags;
  assign addr_mode_o  = out_q.addr_mode;
  assign reg_count_o  = out_q.reg_count;
  assign base_reg_o   = out_q.base_reg;
  assign word_value_o = out_q.word_value;
  assign reg_b_o      = out_q.reg_b;
  assign reg_c_o      = out_q.reg_c;
  assign target_o     = out_q.target;

endmodule
